// ===== rtl/core/lps_pkg.sv =====
// -----------------------------------------------------------------------------
// lps_pkg: shared types and constants for the latency percentile unit
// Holds the sample and result widths, the percentile constants, the controller
// state type and the command and status groups between controller and datapath.
// -----------------------------------------------------------------------------
package lps_pkg;

   // Field widths of the request and response words.
   localparam int LPS_SAMPLE_W = 32;
   localparam int LPS_COUNT_W  = 11;

   // Default store depth.
   localparam int LPS_MAX_SAMPLES = 1024;

   // Nearest-rank arithmetic: rank = ceil(n * p / 100).
   localparam int LPS_RANK_ROUND = 99;
   localparam int LPS_PCT_DIV    = 100;
   localparam int LPS_PCT_W      = 7;
   localparam int LPS_P50        = 50;
   localparam int LPS_P95        = 95;
   localparam int LPS_P99        = 99;

   // Controller states.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_LAUNCH,
      ST_DRAIN,
      ST_PUBLISH
   } lps_state_type;

   // Which percentile a rank calculation belongs to.
   typedef enum logic [1:0] {
      PCT_P50,
      PCT_P95,
      PCT_P99
   } lps_pct_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        store;
      logic        launch;
      lps_pct_type pct;
      logic        publish;
   } lps_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
   } lps_stat_type;

   // One result word as held in the output register.
   typedef struct packed {
      logic [LPS_COUNT_W-1:0]  count;
      logic [LPS_SAMPLE_W-1:0] min_us;
      logic [LPS_SAMPLE_W-1:0] max_us;
      logic [LPS_SAMPLE_W-1:0] p50_us;
      logic [LPS_SAMPLE_W-1:0] p95_us;
      logic [LPS_SAMPLE_W-1:0] p99_us;
      logic [LPS_SAMPLE_W-1:0] spread_us;
      logic                    overflow;
   } lps_result_type;

endpackage

// ===== rtl/core/lps_req_if.sv =====
// -----------------------------------------------------------------------------
// lps_req_if: sample request channel
// Valid/ready channel that carries one latency sample and its last-of-set flag.
// -----------------------------------------------------------------------------
interface lps_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_us;
   logic        last_sample;

   modport source (output valid, output sample_us, output last_sample, input ready);
   modport sink   (input valid, input sample_us, input last_sample, output ready);
endinterface

// ===== rtl/core/lps_rsp_if.sv =====
// -----------------------------------------------------------------------------
// lps_rsp_if: statistics response channel
// Valid/ready channel that carries one statistics word per finished set.
// -----------------------------------------------------------------------------
interface lps_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] count;
   logic [31:0] min_us;
   logic [31:0] max_us;
   logic [31:0] p50_us;
   logic [31:0] p95_us;
   logic [31:0] p99_us;
   logic [31:0] spread_us;
   logic        overflow;

   modport source (output valid, output count, output min_us, output max_us,
                   output p50_us, output p95_us, output p99_us, output spread_us,
                   output overflow, input ready);
   modport sink   (input valid, input count, input min_us, input max_us,
                   input p50_us, input p95_us, input p99_us, input spread_us,
                   input overflow, output ready);
endinterface

// ===== rtl/core/lps_ctrl.sv =====
// -----------------------------------------------------------------------------
// lps_ctrl: sequencing controller
// Accepts samples, issues the three rank calculations after the last sample,
// waits for the rank pipeline to drain and moves the result to the output.
// -----------------------------------------------------------------------------
module lps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  lps_pkg::lps_stat_type stat,
   output lps_pkg::lps_cmd_type  cmd
);
   import lps_pkg::*;

   lps_state_type state_ff, state_in;
   lps_pct_type   pct_ff, pct_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          slot_free;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_last) state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            if (pct_ff == PCT_P99) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!stat.busy) state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (slot_free) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs and percentile sequencing.
   always_comb begin
      req_ready   = 1'b0;
      cmd.store   = 1'b0;
      cmd.launch  = 1'b0;
      cmd.pct     = pct_ff;
      cmd.publish = 1'b0;
      pct_in      = PCT_P50;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.store = req_valid;
         end
         ST_LAUNCH: begin
            cmd.launch = 1'b1;
            case (pct_ff)
               PCT_P50: pct_in = PCT_P95;
               PCT_P95: pct_in = PCT_P99;
               default: pct_in = PCT_P50;
            endcase
         end
         ST_DRAIN: begin
            cmd.launch = 1'b0;
         end
         ST_PUBLISH: begin
            cmd.publish = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // The response valid flag is set on publish and cleared when the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pct_ff       <= PCT_P50;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pct_ff       <= pct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The input closes right after the last sample of a set.
   a_close_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> !req_ready)
      else $error("input still open after last sample");

   // A result never overwrites a word that has not been taken.
   a_publish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> slot_free)
      else $error("publish into an occupied output register");

   // Results are published only once the rank pipeline is empty.
   a_publish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !stat.busy)
      else $error("publish while rank pipeline busy");

endmodule

// ===== rtl/core/lps_dp.sv =====
// -----------------------------------------------------------------------------
// lps_dp: sample store and rank datapath
// Stores samples in a memory, tracks first, last, count and overflow, and runs
// a four-stage rank pipeline that turns a percentile into a memory read.
// -----------------------------------------------------------------------------
module lps_dp #(
   parameter int MAX_SAMPLES = lps_pkg::LPS_MAX_SAMPLES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lps_pkg::LPS_SAMPLE_W-1:0]    sample_us,
   input  lps_pkg::lps_cmd_type                cmd,
   output lps_pkg::lps_stat_type               stat,
   output lps_pkg::lps_result_type             result
);
   import lps_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int XW = CW + 7;
   localparam int MW = XW - 6;
   localparam int PW = XW + MW;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << XW) / 64'd100);

   logic [LPS_SAMPLE_W-1:0] mem [MAX_SAMPLES];

   logic [CW-1:0]           count_ff, count_in;
   logic                    dropped_ff, dropped_in;
   logic [LPS_SAMPLE_W-1:0] first_ff, last_ff;
   logic                    room;

   // Rank pipeline.
   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   lps_pct_type             t1_ff, t2_ff, t3_ff, t4_ff;
   logic [XW-1:0]           x1_ff, x2_ff;
   logic [PW-1:0]           prod_ff;
   logic [AW-1:0]           addr3_ff;
   logic [LPS_SAMPLE_W-1:0] rd_ff;
   logic [LPS_SAMPLE_W-1:0] p50_ff, p95_ff, p99_ff;
   logic [LPS_PCT_W-1:0]    pct_val;
   logic [XW-1:0]           x1_in;
   logic [MW-1:0]           q0;
   logic [XW-1:0]           rem;
   logic [MW:0]             q_full;
   logic [MW:0]             idx;
   logic [MW:0]             n_m1;
   logic [MW:0]             idx_clamp;

   lps_result_type          out_ff;

   assign room = count_ff < CW'(MAX_SAMPLES);

   // Sample count and overflow flag; both clear when a result is published.
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.publish) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.store) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // Sample memory write and the first and last samples of the set.
   always_ff @(posedge clock) begin
      if (cmd.store && room) begin
         mem[count_ff[AW-1:0]] <= sample_us;
         last_ff               <= sample_us;
         if (count_ff == '0) first_ff <= sample_us;
      end
   end

   // Stage 1: rounded product n * p + 99.
   always_comb begin
      case (cmd.pct)
         PCT_P50: pct_val = LPS_PCT_W'(LPS_P50);
         PCT_P95: pct_val = LPS_PCT_W'(LPS_P95);
         PCT_P99: pct_val = LPS_PCT_W'(LPS_P99);
         default: pct_val = LPS_PCT_W'(LPS_P50);
      endcase
      x1_in = XW'(count_ff) * XW'(pct_val) + XW'(LPS_RANK_ROUND);
   end

   // Stage 3: quotient correction, rank to index and clamp to the last entry.
   always_comb begin
      q0        = prod_ff[PW-1:XW];
      rem       = x2_ff - XW'(q0) * XW'(LPS_PCT_DIV);
      q_full    = {1'b0, q0} + ((rem >= XW'(LPS_PCT_DIV)) ? (MW+1)'(1) : '0);
      idx       = (q_full == '0) ? '0 : q_full - (MW+1)'(1);
      n_m1      = (MW+1)'(count_ff) - (MW+1)'(1);
      idx_clamp = (idx > n_m1) ? n_m1 : idx;
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.launch;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Pipeline payload: multiply by the reciprocal of 100, index, memory read.
   always_ff @(posedge clock) begin
      x1_ff    <= x1_in;
      t1_ff    <= cmd.pct;
      prod_ff  <= PW'(x1_ff) * PW'(RECIP);
      x2_ff    <= x1_ff;
      t2_ff    <= t1_ff;
      addr3_ff <= idx_clamp[AW-1:0];
      t3_ff    <= t2_ff;
      rd_ff    <= mem[addr3_ff];
      t4_ff    <= t3_ff;
   end

   // Percentile capture.
   always_ff @(posedge clock) begin
      if (v4_ff) begin
         case (t4_ff)
            PCT_P50: p50_ff <= rd_ff;
            PCT_P95: p95_ff <= rd_ff;
            default: p99_ff <= rd_ff;
         endcase
      end
   end

   // Output register, loaded when the controller publishes.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_ff.count     <= LPS_COUNT_W'(count_ff);
         out_ff.min_us    <= first_ff;
         out_ff.max_us    <= last_ff;
         out_ff.p50_us    <= p50_ff;
         out_ff.p95_us    <= p95_ff;
         out_ff.p99_us    <= p99_ff;
         out_ff.spread_us <= (p95_ff >= p50_ff) ? (p95_ff - p50_ff) : '0;
         out_ff.overflow  <= dropped_ff;
      end
   end

   assign stat.busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign result    = out_ff;

   // The count never passes the store depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("sample count beyond store depth");

   // Storing never overlaps rank calculation or publishing.
   a_store_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (!cmd.launch && !cmd.publish && !stat.busy))
      else $error("store during rank calculation");

   // Publishing empties the set.
   a_publish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> (count_ff == '0 && !dropped_ff))
      else $error("set not emptied after publish");

endmodule

// ===== rtl/core/latency_percentile_stats_unit.sv =====
// -----------------------------------------------------------------------------
// latency_percentile_stats_unit: nearest-rank latency statistics
// Top level: joins the sequencing controller and the store and rank datapath.
// -----------------------------------------------------------------------------
// Usage:
//   req_if carries one sorted latency sample per word; last_sample marks the
//   end of a set. rsp_if returns one word per set: count, min, max, the 50th,
//   95th and 99th nearest-rank percentiles, spread (p95 - p50, floored at
//   zero) and an overflow flag when samples beyond the store depth were lost.
//   Samples are taken at one word per cycle. After the last sample the input
//   closes: three rank calculations issue one per cycle into a four-stage
//   pipeline (multiply by the reciprocal of 100, index correction, one
//   registered read of the sample memory), which drains before the result
//   is moved to the output register. The three percentiles share the single
//   memory read port.
//   While a result waits in the output register, the next set loads; if that
//   set ends before the receiver takes the word, the new result holds in the
//   datapath and the input stays closed until the output register frees.
//   Reset empties the set and drops any pending result; the memory needs no
//   clearing since only entries of the current set are read.
// -----------------------------------------------------------------------------
module latency_percentile_stats_unit #(
   parameter int MAX_SAMPLES = lps_pkg::LPS_MAX_SAMPLES
) (
   input  logic        clock,
   input  logic        reset,
   lps_req_if.sink     req_if,
   lps_rsp_if.source   rsp_if
);
   import lps_pkg::*;

   lps_cmd_type    cmd;
   lps_stat_type   stat;
   lps_result_type result;

   lps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_sample),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   lps_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .sample_us (req_if.sample_us),
      .cmd       (cmd),
      .stat      (stat),
      .result    (result)
   );

   // Response word fields.
   assign rsp_if.count     = result.count;
   assign rsp_if.min_us    = result.min_us;
   assign rsp_if.max_us    = result.max_us;
   assign rsp_if.p50_us    = result.p50_us;
   assign rsp_if.p95_us    = result.p95_us;
   assign rsp_if.p99_us    = result.p99_us;
   assign rsp_if.spread_us = result.spread_us;
   assign rsp_if.overflow  = result.overflow;

endmodule
